/* hw/rtl/pes_pkg.sv */
package pes_pkg;

  localparam int DIV_LAT  = 64;
  localparam int SQRT_LAT = 32;

  localparam logic [1:0] CFG_TIME_STEP      = 2'd0;
  localparam logic [1:0] CFG_FLOOR_LEVEL    = 2'd1;
  localparam logic [1:0] CFG_SPEED_LIMIT    = 2'd2;
  localparam logic [1:0] CFG_BOUNCE_DAMPING = 2'd3;

  localparam logic [15:0] TIME_STEP_RST      = 16'd1092;
  localparam logic [31:0] FLOOR_LEVEL_RST    = 32'd39256064;
  localparam logic [30:0] SPEED_LIMIT_RST    = 31'd65536000;
  localparam logic [16:0] BOUNCE_DAMPING_RST = 17'd13107;

  typedef struct packed {
    logic        vld;
    logic        pin;
    logic        fsx;
    logic        fsy;
    logic        bnc;
    logic        clp;
    logic [31:0] m;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] opx;
    logic [31:0] opy;
    logic [31:0] ovx;
    logic [31:0] ovy;
    logic [63:0] na;
    logic [63:0] nb;
    logic [31:0] s;
  } item_t;

  function automatic logic [31:0] mag32(logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [31:0] sat32(logic [63:0] v);
    logic signed [63:0] sv;
    sv = $signed(v);
    if (sv > 64'sd2147483647) return 32'h7fff_ffff;
    if (sv < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] sext32(logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  // (p >> 16) with sign applied, saturated
  function automatic logic [31:0] scale_res(logic [63:0] p, logic neg);
    logic [63:0] sh;
    sh = p >> 16;
    return sat32(neg ? (~sh + 64'd1) : sh);
  endfunction

  // one restoring step: shift the quotient bit into the low end
  function automatic logic [95:0] div_step(logic [95:0] acc, logic [31:0] den);
    logic [32:0] top;
    logic [32:0] dif;
    top = acc[95:63];
    dif = top - {1'b0, den};
    if (top >= {1'b0, den}) return {dif[31:0], acc[62:0], 1'b1};
    return {top[31:0], acc[62:0], 1'b0};
  endfunction

endpackage

/* hw/rtl/pes_div.sv */
module pes_div (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic [63:0] quo
);

  logic [95:0] acc_r [pes_pkg::DIV_LAT];
  logic [31:0] den_r [pes_pkg::DIV_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r[0] <= pes_pkg::div_step({32'd0, num}, den);
      den_r[0] <= den;
      for (int k = 1; k < pes_pkg::DIV_LAT; k++) begin
        acc_r[k] <= pes_pkg::div_step(acc_r[k-1], den_r[k-1]);
        den_r[k] <= den_r[k-1];
      end
    end
  end

  assign quo = acc_r[pes_pkg::DIV_LAT-1][63:0];

endmodule

/* hw/rtl/pes_sqrt.sv */
module pes_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rad,
  output logic [31:0] root
);

  logic [63:0] n_r [pes_pkg::SQRT_LAT];
  logic [63:0] r_r [pes_pkg::SQRT_LAT];

  function automatic logic [127:0] sq_step(logic [63:0] n, logic [63:0] res, logic [63:0] b);
    logic [63:0] t;
    t = res + b;
    if (n >= t) return {n - t, (res >> 1) + b};
    return {n, res >> 1};
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      {n_r[0], r_r[0]} <= sq_step(rad, 64'd0, 64'd1 << 62);
      for (int k = 1; k < pes_pkg::SQRT_LAT; k++) begin
        {n_r[k], r_r[k]} <= sq_step(n_r[k-1], r_r[k-1], 64'd1 << (62 - 2 * k));
      end
    end
  end

  assign root = r_r[pes_pkg::SQRT_LAT-1][31:0];

endmodule

/* hw/rtl/particle_euler_step_top.sv */
// One semi-implicit Euler step per particle, fully pipelined: a new particle
// is taken every cycle while in_stall is low. Most of the pipeline depth
// comes from two pairs of 64-stage bit-per-stage dividers (force/mass, then
// the speed rescale) and a 32-stage square root. A stall on the result side
// freezes the whole pipeline while the output register holds a result.
// Configuration writes are always ready; the stages read the registers as
// each particle passes, and the squared speed limit is registered from the
// speed limit register, so write them only while no particle is in flight.
module particle_euler_step_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_position_x,
  input  logic [31:0] in_position_y,
  input  logic [31:0] in_velocity_x,
  input  logic [31:0] in_velocity_y,
  input  logic [31:0] in_force_x,
  input  logic [31:0] in_force_y,
  input  logic [31:0] in_particle_mass,
  input  logic        in_is_pinned,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_new_position_x,
  output logic [31:0] out_new_position_y,
  output logic [31:0] out_new_velocity_x,
  output logic [31:0] out_new_velocity_y,
  output logic        out_bounced,
  output logic        out_speed_clamped,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [15:0] ts_r;
  logic [31:0] fl_r;
  logic [30:0] sl_r;
  logic [16:0] bd_r;
  logic [63:0] lsq_r;

  logic en;
  pes_pkg::item_t s1_r, s2_r, s3_r, s4_r, s5_r, s6_r, s7_r, s8_r, s9_r, s10_r, s11_r;
  pes_pkg::item_t s1_nxt, s2_nxt, s3_nxt, s4_nxt, s5_nxt, s6_nxt, s7_nxt, s8_nxt;
  pes_pkg::item_t s9_nxt, s10_nxt, s11_nxt, o_nxt;
  pes_pkg::item_t d1_r [pes_pkg::DIV_LAT];
  pes_pkg::item_t d2_r [pes_pkg::SQRT_LAT];
  pes_pkg::item_t d3_r [pes_pkg::DIV_LAT];

  logic [63:0] q1x, q1y, q2x, q2y;
  logic [31:0] root;

  logic        out_vld_r;
  logic [31:0] out_px_r, out_py_r, out_vx_r, out_vy_r;
  logic        out_bnc_r, out_clp_r;

  assign en        = !out_vld_r || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r <= pes_pkg::TIME_STEP_RST;
      fl_r <= pes_pkg::FLOOR_LEVEL_RST;
      sl_r <= pes_pkg::SPEED_LIMIT_RST;
      bd_r <= pes_pkg::BOUNCE_DAMPING_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        pes_pkg::CFG_TIME_STEP:      ts_r <= cfg_data[15:0];
        pes_pkg::CFG_FLOOR_LEVEL:    fl_r <= cfg_data;
        pes_pkg::CFG_SPEED_LIMIT:    sl_r <= cfg_data[30:0];
        pes_pkg::CFG_BOUNCE_DAMPING: bd_r <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    lsq_r <= {33'd0, sl_r} * {33'd0, sl_r};
  end

  // capture
  always_comb begin
    s1_nxt     = '0;
    s1_nxt.vld = in_valid;
    s1_nxt.pin = in_is_pinned;
    s1_nxt.fsx = in_force_x[31];
    s1_nxt.fsy = in_force_y[31];
    s1_nxt.m   = in_particle_mass;
    s1_nxt.px  = in_position_x;
    s1_nxt.py  = in_position_y;
    s1_nxt.vx  = in_velocity_x;
    s1_nxt.vy  = in_velocity_y;
    s1_nxt.opx = in_position_x;
    s1_nxt.opy = in_position_y;
    s1_nxt.ovx = in_velocity_x;
    s1_nxt.ovy = in_velocity_y;
    s1_nxt.na  = pes_pkg::sext32(in_force_x);
    s1_nxt.nb  = pes_pkg::sext32(in_force_y);
  end

  // |force| * time_step
  always_comb begin
    s2_nxt    = s1_r;
    s2_nxt.na = {32'd0, pes_pkg::mag32(s1_r.na[31:0])} * {48'd0, ts_r};
    s2_nxt.nb = {32'd0, pes_pkg::mag32(s1_r.nb[31:0])} * {48'd0, ts_r};
  end

  pes_div u_div_fx (.clk(clk), .en(en), .num(s2_r.na), .den(s2_r.m), .quo(q1x));
  pes_div u_div_fy (.clk(clk), .en(en), .num(s2_r.nb), .den(s2_r.m), .quo(q1y));

  // velocity update; skip when mass is zero
  always_comb begin
    pes_pkg::item_t it;
    logic [63:0] ix, iy;
    it = d1_r[pes_pkg::DIV_LAT-1];
    ix = it.fsx ? (~q1x + 64'd1) : q1x;
    iy = it.fsy ? (~q1y + 64'd1) : q1y;
    s3_nxt = it;
    if (it.m != 32'd0) begin
      s3_nxt.vx = pes_pkg::sat32(pes_pkg::sext32(it.vx) + ix);
      s3_nxt.vy = pes_pkg::sat32(pes_pkg::sext32(it.vy) + iy);
    end
  end

  always_comb begin
    s4_nxt    = s3_r;
    s4_nxt.na = {32'd0, pes_pkg::mag32(s3_r.vx)} * {48'd0, ts_r};
    s4_nxt.nb = {32'd0, pes_pkg::mag32(s3_r.vy)} * {48'd0, ts_r};
  end

  always_comb begin
    s5_nxt    = s4_r;
    s5_nxt.px = pes_pkg::sat32(pes_pkg::sext32(s4_r.px) +
                pes_pkg::sext32(pes_pkg::scale_res(s4_r.na, s4_r.vx[31])));
    s5_nxt.py = pes_pkg::sat32(pes_pkg::sext32(s4_r.py) +
                pes_pkg::sext32(pes_pkg::scale_res(s4_r.nb, s4_r.vy[31])));
  end

  // floor test
  always_comb begin
    s6_nxt = s5_r;
    if ($signed(s5_r.py) > $signed(fl_r)) begin
      s6_nxt.bnc = 1'b1;
      s6_nxt.py  = fl_r;
      if (!s5_r.vy[31] && s5_r.vy != 32'd0) s6_nxt.vy = ~s5_r.vy + 32'd1;
    end
  end

  always_comb begin
    s7_nxt    = s6_r;
    s7_nxt.na = {32'd0, pes_pkg::mag32(s6_r.vx)} * {47'd0, bd_r};
    s7_nxt.nb = {32'd0, pes_pkg::mag32(s6_r.vy)} * {47'd0, bd_r};
  end

  always_comb begin
    s8_nxt = s7_r;
    if (s7_r.bnc) begin
      s8_nxt.vx = pes_pkg::scale_res(s7_r.na, s7_r.vx[31]);
      s8_nxt.vy = pes_pkg::scale_res(s7_r.nb, s7_r.vy[31]);
    end
  end

  always_comb begin
    s9_nxt    = s8_r;
    s9_nxt.na = {32'd0, pes_pkg::mag32(s8_r.vx)} * {32'd0, pes_pkg::mag32(s8_r.vx)};
    s9_nxt.nb = {32'd0, pes_pkg::mag32(s8_r.vy)} * {32'd0, pes_pkg::mag32(s8_r.vy)};
  end

  always_comb begin
    s10_nxt     = s9_r;
    s10_nxt.na  = s9_r.na + s9_r.nb;
    s10_nxt.clp = (s9_r.na + s9_r.nb) > lsq_r;
  end

  pes_sqrt u_sqrt (.clk(clk), .en(en), .rad(s10_r.na), .root(root));

  always_comb begin
    s11_nxt    = d2_r[pes_pkg::SQRT_LAT-1];
    s11_nxt.s  = root;
    s11_nxt.na = {32'd0, pes_pkg::mag32(s11_nxt.vx)} * {33'd0, sl_r};
    s11_nxt.nb = {32'd0, pes_pkg::mag32(s11_nxt.vy)} * {33'd0, sl_r};
  end

  pes_div u_div_cx (.clk(clk), .en(en), .num(s11_r.na), .den(s11_r.s), .quo(q2x));
  pes_div u_div_cy (.clk(clk), .en(en), .num(s11_r.nb), .den(s11_r.s), .quo(q2y));

  // rescale to the limit, or pass the particle through when pinned
  always_comb begin
    o_nxt = d3_r[pes_pkg::DIV_LAT-1];
    if (o_nxt.clp) begin
      o_nxt.vx = o_nxt.vx[31] ? (~q2x[31:0] + 32'd1) : q2x[31:0];
      o_nxt.vy = o_nxt.vy[31] ? (~q2y[31:0] + 32'd1) : q2y[31:0];
    end
    if (o_nxt.pin) begin
      o_nxt.px  = o_nxt.opx;
      o_nxt.py  = o_nxt.opy;
      o_nxt.vx  = o_nxt.ovx;
      o_nxt.vy  = o_nxt.ovy;
      o_nxt.bnc = 1'b0;
      o_nxt.clp = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld  <= 1'b0;
      s2_r.vld  <= 1'b0;
      s3_r.vld  <= 1'b0;
      s4_r.vld  <= 1'b0;
      s5_r.vld  <= 1'b0;
      s6_r.vld  <= 1'b0;
      s7_r.vld  <= 1'b0;
      s8_r.vld  <= 1'b0;
      s9_r.vld  <= 1'b0;
      s10_r.vld <= 1'b0;
      s11_r.vld <= 1'b0;
      for (int k = 0; k < pes_pkg::DIV_LAT; k++) begin
        d1_r[k].vld <= 1'b0;
        d3_r[k].vld <= 1'b0;
      end
      for (int k = 0; k < pes_pkg::SQRT_LAT; k++) d2_r[k].vld <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      s1_r  <= s1_nxt;
      s2_r  <= s2_nxt;
      d1_r[0] <= s2_r;
      for (int k = 1; k < pes_pkg::DIV_LAT; k++) d1_r[k] <= d1_r[k-1];
      s3_r  <= s3_nxt;
      s4_r  <= s4_nxt;
      s5_r  <= s5_nxt;
      s6_r  <= s6_nxt;
      s7_r  <= s7_nxt;
      s8_r  <= s8_nxt;
      s9_r  <= s9_nxt;
      s10_r <= s10_nxt;
      d2_r[0] <= s10_r;
      for (int k = 1; k < pes_pkg::SQRT_LAT; k++) d2_r[k] <= d2_r[k-1];
      s11_r <= s11_nxt;
      d3_r[0] <= s11_r;
      for (int k = 1; k < pes_pkg::DIV_LAT; k++) d3_r[k] <= d3_r[k-1];
      out_vld_r <= o_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_px_r  <= o_nxt.px;
      out_py_r  <= o_nxt.py;
      out_vx_r  <= o_nxt.vx;
      out_vy_r  <= o_nxt.vy;
      out_bnc_r <= o_nxt.bnc;
      out_clp_r <= o_nxt.clp;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_new_position_x = out_px_r;
  assign out_new_position_y = out_py_r;
  assign out_new_velocity_x = out_vx_r;
  assign out_new_velocity_y = out_vy_r;
  assign out_bounced        = out_bnc_r;
  assign out_speed_clamped  = out_clp_r;

endmodule
